// ===== hw/rtl/lms_adaptive_fir_multimode_macros.svh =====
// Assertion helpers for the checker file of this block.
`ifndef LMS_ADAPTIVE_FIR_MULTIMODE_MACROS_SVH
`define LMS_ADAPTIVE_FIR_MULTIMODE_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define LMSF_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define LMSF_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that is checked during reset as well.
`define LMSF_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/lmsf_pkg.sv =====
`timescale 1ns / 1ps
package lmsf_pkg;

   // Filter length and the widths that follow from it.
   localparam int TAPS       = 16;
   localparam int TAP_CNT_W  = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int GROW_W     = $clog2(TAPS) + 1;

   localparam int SAMPLE_W   = 16;
   localparam int WEIGHT_W   = 24;
   localparam int PROD_W     = SAMPLE_W + WEIGHT_W;
   localparam int SQ_W       = 31;
   localparam int ACC_W      = PROD_W + GROW_W;
   localparam int NORM_W     = SQ_W + GROW_W;
   localparam int DEN_W      = NORM_W + 1;
   localparam int WIDE_W     = 64;
   localparam int UPD_W      = 60;

   localparam int MODE_W     = 3;
   localparam int MU_W       = 16;
   localparam int REG_W      = 20;
   localparam int LEAK_W     = 17;
   localparam int Q_W        = 24;
   localparam int DIVIDEND_W = MU_W + 32;

   localparam int CSR_ADDR_W = 8;
   localparam int CSR_DATA_W = 20;

   // Update rules.
   localparam logic [MODE_W-1:0] MODE_LMS        = 3'd0;
   localparam logic [MODE_W-1:0] MODE_NLMS       = 3'd1;
   localparam logic [MODE_W-1:0] MODE_SIGN_ERROR = 3'd2;
   localparam logic [MODE_W-1:0] MODE_SIGN_DATA  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_SIGN_SIGN  = 3'd4;
   localparam logic [MODE_W-1:0] MODE_LEAKY      = 3'd5;

   // Register indexes.
   localparam logic [CSR_ADDR_W-1:0] CSR_UPDATE_MODE = 8'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_STEP_SIZE   = 8'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_REGULARIZER = 8'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_LEAK_FACTOR = 8'd3;

   // Register reset values.
   localparam logic [MU_W-1:0]   STEP_RESET = 16'd655;
   localparam logic [REG_W-1:0]  REG_RESET  = 20'd1074;
   localparam logic [LEAK_W-1:0] LEAK_ONE   = 17'd65536;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] new_sample;
      logic signed [SAMPLE_W-1:0] desired;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] filter_out;
      logic signed [SAMPLE_W-1:0] error_out;
   } rsp_type;

   // Control that every cell of the chain sees.
   typedef struct packed {
      logic shift_x;
      logic rotate;
   } cell_ctl_type;

   // Saturates a wide signed value to a Q1.15 sample.
   function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [WIDE_W-1:0] v);
      logic signed [SAMPLE_W-1:0] r;
      if (v > 64'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -64'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[SAMPLE_W-1:0];
      end
      return r;
   endfunction

   // Saturates a wide signed value to a Q4.20 weight.
   function automatic logic signed [WEIGHT_W-1:0] sat24(input logic signed [UPD_W-1:0] v);
      logic signed [WEIGHT_W-1:0] r;
      if (v > 60'sd8388607) begin
         r = 24'sh7fffff;
      end else if (v < -60'sd8388608) begin
         r = 24'sh800000;
      end else begin
         r = v[WEIGHT_W-1:0];
      end
      return r;
   endfunction

   // Round half up, then drop the low bits.
   function automatic logic signed [UPD_W-1:0] round_shift(input logic signed [UPD_W-1:0] v,
                                                           input int s);
      logic signed [UPD_W-1:0] half;
      half = 60'sd1 <<< (s - 1);
      return (v + half) >>> s;
   endfunction

endpackage

// ===== hw/rtl/lmsf_cell.sv =====
`timescale 1ns / 1ps
module lmsf_cell import lmsf_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  cell_ctl_type               ctl,
   input  logic signed [SAMPLE_W-1:0] x_prev,
   input  logic signed [WEIGHT_W-1:0] w_prev,
   output logic signed [SAMPLE_W-1:0] x,
   output logic signed [WEIGHT_W-1:0] w
);

   logic signed [SAMPLE_W-1:0] x_ff, x_in;
   logic signed [WEIGHT_W-1:0] w_ff, w_in;

   // The sample moves on a shift or a rotation; the weight moves only on a rotation.
   always_comb begin
      x_in = (ctl.shift_x || ctl.rotate) ? x_prev : x_ff;
      w_in = ctl.rotate ? w_prev : w_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= '0;
         w_ff <= '0;
      end else begin
         x_ff <= x_in;
         w_ff <= w_in;
      end
   end

   assign x = x_ff;
   assign w = w_ff;

endmodule

// ===== hw/rtl/lmsf_div.sv =====
`timescale 1ns / 1ps
module lmsf_div import lmsf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DEN_W-1:0]      divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DEN_W-1:0]      rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DEN_W:0]        trial;
   logic                  fits;

   // One quotient bit per cycle, restoring form.
   always_comb begin
      trial   = {rem_ff, quo_ff[DIVIDEND_W-1]};
      fits    = trial >= {1'b0, divisor};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? DEN_W'(trial - {1'b0, divisor}) : trial[DEN_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== hw/rtl/lms_adaptive_fir_multimode.sv =====
`timescale 1ns / 1ps
// Channel   Ports                      Moves
// input     req_valid/ready, req_data  new_sample, desired
// result    rsp_valid/ready, rsp_data  filter_out, error_out
// config    csr_we, csr_addr, csr_wdata one register write, no wait
//
// The dot product rotates the cell ring once, then normalized mode runs the
// one-bit-per-cycle divider. The update rotates the ring again, taking each tap through
// the shared multipliers in the steps MUL1, MUL2 and WRITE.
// A new item is taken while a finished result still waits; the block stalls before
// loading its next result until the previous one is taken.
// Reset is synchronous and clears the delay line, the weights and the registers.
module lms_adaptive_fir_multimode import lmsf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DOT   = 3'd1;
   localparam logic [2:0] ST_DRAIN = 3'd2;
   localparam logic [2:0] ST_FINAL = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_UPD   = 3'd5;

   localparam logic [1:0] PH_MUL1  = 2'd0;
   localparam logic [1:0] PH_MUL2  = 2'd1;
   localparam logic [1:0] PH_WRITE = 2'd2;

   logic [2:0]           state_ff, state_in;
   logic [1:0]           phase_ff, phase_in;
   logic [TAP_CNT_W-1:0] tap_ff, tap_in;

   logic [MODE_W-1:0]    mode_ff;
   logic [MU_W-1:0]      mu_ff;
   logic [REG_W-1:0]     reg_ff;
   logic [LEAK_W-1:0]    leak_ff;

   logic signed [SAMPLE_W-1:0] x_q [TAPS];
   logic signed [WEIGHT_W-1:0] w_q [TAPS];
   logic signed [SAMPLE_W-1:0] x_chain [TAPS];
   logic signed [WEIGHT_W-1:0] w_chain [TAPS];
   logic signed [SAMPLE_W-1:0] x_last;
   logic signed [WEIGHT_W-1:0] w_last;
   cell_ctl_type               ctl;

   logic req_fire, final_go, div_done, div_start;

   logic signed [PROD_W-1:0] prod_ff;
   logic [SQ_W-1:0]          sq_ff;
   logic                     pvld_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic [NORM_W-1:0]        norm_ff;
   logic signed [31:0]       sq_full;

   logic signed [SAMPLE_W-1:0] req_data_hold;
   logic signed [WIDE_W-1:0]   y_wide;
   logic signed [WIDE_W-1:0]   diff_wide;
   logic signed [SAMPLE_W-1:0] e_now;
   logic signed [SAMPLE_W-1:0] e_ff;
   rsp_type                    rsp_ff;
   logic                       rsp_valid_ff;

   logic [DEN_W-1:0]      den;
   logic [DIVIDEND_W-1:0] quotient;
   logic [Q_W-1:0]        q_ff;

   logic signed [31:0]       p1_in, p1_ff;
   logic signed [Q_W:0]      coef;
   logic [LEAK_W-1:0]        gamma;
   logic signed [UPD_W-1:0]  prod2_ff, leakp_ff;
   logic signed [UPD_W-1:0]  nw_full;
   logic signed [WEIGHT_W-1:0] nw;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign x_last    = x_q[TAPS-1];
   assign w_last    = w_q[TAPS-1];

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_LMS;
         mu_ff   <= STEP_RESET;
         reg_ff  <= REG_RESET;
         leak_ff <= LEAK_ONE;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_UPDATE_MODE: mode_ff <= csr_wdata[MODE_W-1:0];
            CSR_STEP_SIZE:   mu_ff   <= csr_wdata[MU_W-1:0];
            CSR_REGULARIZER: reg_ff  <= csr_wdata[REG_W-1:0];
            CSR_LEAK_FACTOR: leak_ff <= csr_wdata[LEAK_W-1:0];
            default: ;
         endcase
      end
   end

   // Cell ring: the head cell takes the new sample on a shift, and the tail on a rotation.
   assign ctl.shift_x = req_fire;
   assign ctl.rotate  = (state_ff == ST_DOT) || (state_ff == ST_UPD && phase_ff == PH_WRITE);

   always_comb begin
      x_chain[0] = req_fire ? req_data.new_sample : x_last;
      w_chain[0] = (state_ff == ST_UPD) ? nw : w_last;
      for (int i = 1; i < TAPS; i++) begin
         x_chain[i] = x_q[i-1];
         w_chain[i] = w_q[i-1];
      end
   end

   for (genvar g = 0; g < TAPS; g++) begin : g_cell
      lmsf_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .ctl    (ctl),
         .x_prev (x_chain[g]),
         .w_prev (w_chain[g]),
         .x      (x_q[g]),
         .w      (w_q[g])
      );
   end

   // Dot product and squared norm, one tap per cycle with a registered product.
   assign sq_full = 32'(x_last) * 32'(x_last);

   always_ff @(posedge clock) begin
      if (reset) begin
         pvld_ff <= 1'b0;
      end else begin
         pvld_ff <= (state_ff == ST_DOT);
      end
      prod_ff <= PROD_W'(w_last) * PROD_W'(x_last);
      sq_ff   <= sq_full[SQ_W-1:0];
      if (req_fire) begin
         acc_ff  <= '0;
         norm_ff <= '0;
      end else if (pvld_ff) begin
         acc_ff  <= acc_ff + ACC_W'(prod_ff);
         norm_ff <= norm_ff + NORM_W'(sq_ff);
      end
   end

   // Output and error from the finished sum.
   always_comb begin
      y_wide    = (WIDE_W'(acc_ff) + 64'sd524288) >>> 20;
      diff_wide = WIDE_W'(req_data_hold) - y_wide;
      e_now     = sat16(diff_wide);
   end

   // Desired value is kept from the accepted item.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_data_hold <= req_data.desired;
      end
   end

   assign final_go = (state_ff == ST_FINAL) && (!rsp_valid_ff || rsp_ready);

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (final_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (final_go) begin
         rsp_ff.filter_out <= sat16(y_wide);
         rsp_ff.error_out  <= e_now;
         e_ff              <= e_now;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Normalized step: mu * 2^32 over regularizer plus norm.
   assign den       = DEN_W'(norm_ff) + DEN_W'(reg_ff);
   assign div_start = final_go && (mode_ff == MODE_NLMS);

   lmsf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({mu_ff, 32'd0}),
      .divisor  (den),
      .done     (div_done),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (div_done) begin
         if (den == '0) begin
            q_ff <= '0;
         end else if (quotient[DIVIDEND_W-1:Q_W] != '0) begin
            q_ff <= '1;
         end else begin
            q_ff <= quotient[Q_W-1:0];
         end
      end
   end

   // Weight update: first product of error and sample, with signs where the rule asks.
   always_comb begin
      case (mode_ff)
         MODE_SIGN_ERROR: begin
            if (e_ff[SAMPLE_W-1]) begin
               p1_in = -32'(x_last);
            end else if (e_ff != '0) begin
               p1_in = 32'(x_last);
            end else begin
               p1_in = '0;
            end
         end
         MODE_SIGN_DATA: begin
            if (x_last[SAMPLE_W-1]) begin
               p1_in = -32'(e_ff);
            end else if (x_last != '0) begin
               p1_in = 32'(e_ff);
            end else begin
               p1_in = '0;
            end
         end
         MODE_SIGN_SIGN: begin
            if (e_ff == '0 || x_last == '0) begin
               p1_in = '0;
            end else if (e_ff[SAMPLE_W-1] ^ x_last[SAMPLE_W-1]) begin
               p1_in = -32'sd1;
            end else begin
               p1_in = 32'sd1;
            end
         end
         default: p1_in = 32'(e_ff) * 32'(x_last);
      endcase
      coef  = (mode_ff == MODE_NLMS) ? $signed({1'b0, q_ff}) : $signed((Q_W + 1)'(mu_ff));
      gamma = (leak_ff > LEAK_ONE) ? LEAK_ONE : leak_ff;
   end

   // Second products: step times the first product, and leak times the weight.
   always_ff @(posedge clock) begin
      if (phase_ff == PH_MUL1) begin
         p1_ff <= p1_in;
      end
      if (phase_ff == PH_MUL2) begin
         prod2_ff <= UPD_W'(coef) * UPD_W'(p1_ff);
         leakp_ff <= UPD_W'($signed({1'b0, gamma})) * UPD_W'(w_last);
      end
   end

   // New weight, rounded and saturated.
   always_comb begin
      case (mode_ff)
         MODE_LMS:        nw_full = UPD_W'(w_last) + round_shift(prod2_ff, 26);
         MODE_NLMS:       nw_full = UPD_W'(w_last) + round_shift(prod2_ff, 28);
         MODE_SIGN_ERROR: nw_full = UPD_W'(w_last) + round_shift(prod2_ff, 11);
         MODE_SIGN_DATA:  nw_full = UPD_W'(w_last) + round_shift(prod2_ff, 11);
         MODE_SIGN_SIGN:  nw_full = UPD_W'(w_last) + round_shift(prod2_ff, 4);
         MODE_LEAKY:      nw_full = round_shift((leakp_ff <<< 10) + prod2_ff, 26);
         default:         nw_full = UPD_W'(w_last);
      endcase
      nw = sat24(nw_full);
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      tap_in   = tap_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_DOT;
               tap_in   = '0;
            end
         end
         ST_DOT: begin
            if (tap_ff == TAP_CNT_W'(TAPS - 1)) begin
               state_in = ST_DRAIN;
               tap_in   = '0;
            end else begin
               tap_in = tap_ff + 1'b1;
            end
         end
         ST_DRAIN: state_in = ST_FINAL;
         ST_FINAL: begin
            if (final_go) begin
               state_in = (mode_ff == MODE_NLMS) ? ST_DIV : ST_UPD;
               phase_in = PH_MUL1;
               tap_in   = '0;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            unique case (phase_ff)
               PH_MUL1: phase_in = PH_MUL2;
               PH_MUL2: phase_in = PH_WRITE;
               default: begin
                  phase_in = PH_MUL1;
                  if (tap_ff == TAP_CNT_W'(TAPS - 1)) begin
                     state_in = ST_IDLE;
                     tap_in   = '0;
                  end else begin
                     tap_in = tap_ff + 1'b1;
                  end
               end
            endcase
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_MUL1;
         tap_ff   <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         tap_ff   <= tap_in;
      end
   end

endmodule

// ===== hw/rtl/lmsf_checker.sv =====
`timescale 1ns / 1ps
`include "lms_adaptive_fir_multimode_macros.svh"
module lmsf_checker import lmsf_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // A waiting result item holds its value until taken.
   `LMSF_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result item dropped or changed while stalled")

   // The block works on one input item at a time.
   `LMSF_ASSERT_NXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "input taken again while busy")

   // A result never appears in the cycle right after its item is accepted.
   `LMSF_ASSERT_IMP(a_no_instant_rsp, clock, reset, $rose(rsp_valid), !$past(req_valid && req_ready), "result appeared too early")

   // Reset leaves no result pending.
   `LMSF_ASSERT_NXT_ALWAYS(a_reset_clears, clock, reset, !rsp_valid, "result pending after reset")

endmodule

bind lms_adaptive_fir_multimode lmsf_checker u_lmsf_checker (.*);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
   import lmsf_pkg::*;

   localparam int STALL_LIMIT = 20000;
   localparam int TAIL_CYCLES = 300;
   localparam int PHASES      = 16;
   localparam int PHASE_ITEMS = 118;
   localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;
   localparam logic [CSR_ADDR_W-1:0] CSR_UNMAPPED = 8'd200;

   // One row of the directed table; check_typed rows carry a hand-written result.
   typedef struct {
      logic [MODE_W-1:0] mode;
      int                sample;
      int                want;
      bit                check_typed;
      int                typed_out;
      int                typed_err;
   } dir_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_type           req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp_data;
   logic              csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Shadow of the filter: registers, delay line and weights.
   logic [MODE_W-1:0] sh_mode;
   longint            sh_step, sh_reg, sh_leak;
   longint            sh_taps [TAPS];
   longint            sh_wts [TAPS];

   rsp_type           pending_rsp [$];
   int                fail_count = 0;
   int                items_sent = 0;
   int                rsps_seen = 0;
   int                idle_pct = 0;
   int                stall_pct = 0;
   int                quiet_cycles = 0;
   int                zero_run = 0;

   dir_row_type dir_tab [22] = '{
      '{MODE_LMS,         32767, -32768, 1'b1, 0, -32768},
      '{MODE_LMS,             0,  32767, 1'b1, 0,  32767},
      '{MODE_LMS,        -32768,      0, 1'b0, 0, 0},
      '{MODE_NLMS,        12000,  -9000, 1'b0, 0, 0},
      '{MODE_NLMS,       -32768,  32767, 1'b0, 0, 0},
      '{MODE_NLMS,            1,     -1, 1'b0, 0, 0},
      '{MODE_SIGN_ERROR,  32767,  32767, 1'b0, 0, 0},
      '{MODE_SIGN_ERROR,     -5, -32768, 1'b0, 0, 0},
      '{MODE_SIGN_ERROR,      0,      0, 1'b0, 0, 0},
      '{MODE_SIGN_DATA,  -32768,  20000, 1'b0, 0, 0},
      '{MODE_SIGN_DATA,       0, -20000, 1'b0, 0, 0},
      '{MODE_SIGN_DATA,    4000,   3000, 1'b0, 0, 0},
      '{MODE_SIGN_SIGN,   32767, -32768, 1'b0, 0, 0},
      '{MODE_SIGN_SIGN,      -1,  32767, 1'b0, 0, 0},
      '{MODE_SIGN_SIGN,       0,      0, 1'b0, 0, 0},
      '{MODE_LEAKY,       25000, -25000, 1'b0, 0, 0},
      '{MODE_LEAKY,      -32768,  32767, 1'b0, 0, 0},
      '{MODE_LEAKY,        -300,    100, 1'b0, 0, 0},
      '{MODE_SPARE6,      32767,  32767, 1'b0, 0, 0},
      '{MODE_SPARE6,     -32768, -32768, 1'b0, 0, 0},
      '{MODE_SPARE7,      21845, -21846, 1'b0, 0, 0},
      '{MODE_SPARE7,          0,  32767, 1'b0, 0, 0}
   };

   lms_adaptive_fir_multimode dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint round_down(input longint v, input int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint sign3(input longint v);
      return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
   endfunction

   function automatic longint clip(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // Runs one sample through the shadow filter and returns the output and error.
   function automatic rsp_type filter_step(input req_type r);
      longint acc, y, e, x, w, nw, q, gain;
      longint unsigned norm, den, quot;
      rsp_type o;
      acc = 0;
      norm = 0;
      q = 0;
      for (int i = TAPS - 1; i > 0; i--) begin
         sh_taps[i] = sh_taps[i-1];
      end
      sh_taps[0] = longint'($signed(r.new_sample));
      for (int i = 0; i < TAPS; i++) begin
         acc += sh_wts[i] * sh_taps[i];
         norm += longint'(sh_taps[i] * sh_taps[i]);
      end
      y = round_down(acc, 20);
      e = clip(longint'($signed(r.desired)) - y, -32768, 32767);
      o.filter_out = 16'(clip(y, -32768, 32767));
      o.error_out = 16'(e);
      if (sh_mode == MODE_NLMS) begin
         den = norm + longint'(sh_reg);
         if (den != 0) begin
            quot = (longint'(sh_step) << 32) / den;
            q = (quot > 64'd16777215) ? 16777215 : longint'(quot);
         end
      end
      gain = (sh_leak > 65536) ? 65536 : sh_leak;
      for (int i = 0; i < TAPS; i++) begin
         x = sh_taps[i];
         w = sh_wts[i];
         case (sh_mode)
            MODE_LMS:        nw = w + round_down(sh_step * e * x, 26);
            MODE_NLMS:       nw = w + round_down(q * e * x, 28);
            MODE_SIGN_ERROR: nw = w + round_down(sh_step * sign3(e) * x, 11);
            MODE_SIGN_DATA:  nw = w + round_down(sh_step * e * sign3(x), 11);
            MODE_SIGN_SIGN:  nw = w + round_down(sh_step * sign3(e) * sign3(x), 4);
            MODE_LEAKY:      nw = round_down(gain * w * 1024 + sh_step * e * x, 26);
            default:         nw = w;
         endcase
         sh_wts[i] = clip(nw, -8388608, 8388607);
      end
      return o;
   endfunction

   // Waits until every expected result has come back and the weight update is over.
   task automatic drain();
      while (pending_rsp.size() != 0 || !req_ready) begin
         @(posedge clock);
      end
   endtask

   // Writes one register and mirrors the write in the shadow copy.
   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_UPDATE_MODE: sh_mode = val[MODE_W-1:0];
         CSR_STEP_SIZE:   sh_step = longint'(val[MU_W-1:0]);
         CSR_REGULARIZER: sh_reg = longint'(val[REG_W-1:0]);
         CSR_LEAK_FACTOR: sh_leak = longint'(val[LEAK_W-1:0]);
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic end_writes();
      csr_we <= 1'b0;
   endtask

   // Offers one item, optionally idling first, and records its expected result.
   task automatic send_item(input req_type r, input bit use_typed, input rsp_type typed);
      rsp_type predicted;
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do begin
            @(posedge clock);
         end while ($urandom_range(99) < idle_pct);
      end
      req_data <= r;
      req_valid <= 1'b1;
      do begin
         @(posedge clock);
      end while (!req_ready);
      predicted = filter_step(r);
      pending_rsp.push_back(use_typed ? typed : predicted);
      items_sent++;
   endtask

   // Random sample: wide, small, extreme, or part of a run of zeros.
   function automatic logic [15:0] pick_sample();
      int sel;
      if (zero_run > 0) begin
         zero_run--;
         return 16'd0;
      end
      sel = $urandom_range(99);
      if (sel < 3) begin
         zero_run = 19;
         return 16'd0;
      end else if (sel < 13) begin
         return $urandom_range(1) ? 16'h7fff : 16'h8000;
      end else if (sel < 45) begin
         return 16'($signed($urandom_range(4000)) - 2000);
      end
      return 16'($urandom);
   endfunction

   // Receiver back-pressure.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Result checker: every taken result against the oldest expectation.
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_valid && rsp_ready) begin
         rsps_seen++;
         if (pending_rsp.size() == 0) begin
            $error("unexpected result item: filter_out %0d error_out %0d",
                   $signed(rsp_data.filter_out), $signed(rsp_data.error_out));
            fail_count++;
         end else begin
            exp_rsp = pending_rsp.pop_front();
            if (rsp_data.filter_out !== exp_rsp.filter_out) begin
               $error("filter_out: expected %0d, got %0d",
                      $signed(exp_rsp.filter_out), $signed(rsp_data.filter_out));
               fail_count++;
            end
            if (rsp_data.error_out !== exp_rsp.error_out) begin
               $error("error_out: expected %0d, got %0d",
                      $signed(exp_rsp.error_out), $signed(rsp_data.error_out));
               fail_count++;
            end
         end
      end
   end

   // Watchdog on cycles without any handshake on the input or the result channel.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      req_type r;
      rsp_type typed;
      logic [CSR_DATA_W-1:0] step_val, reg_val, leak_val;
      sh_mode = MODE_LMS;
      sh_step = 655;
      sh_reg = 1074;
      sh_leak = 65536;
      for (int i = 0; i < TAPS; i++) begin
         sh_taps[i] = 0;
         sh_wts[i] = 0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: each mode in turn with the registers at their reset values.
      foreach (dir_tab[k]) begin
         if (dir_tab[k].mode != sh_mode) begin
            req_valid <= 1'b0;
            drain();
            write_reg(CSR_UPDATE_MODE, CSR_DATA_W'(dir_tab[k].mode));
            end_writes();
         end
         r.new_sample = 16'(dir_tab[k].sample);
         r.desired = 16'(dir_tab[k].want);
         typed.filter_out = 16'(dir_tab[k].typed_out);
         typed.error_out = 16'(dir_tab[k].typed_err);
         send_item(r, dir_tab[k].check_typed, typed);
      end

      // Random part: one register setting and one idle profile per phase.
      for (int p = 0; p < PHASES; p++) begin
         req_valid <= 1'b0;
         drain();
         case (p % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 86; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 86; end
            default: begin idle_pct = 10; stall_pct = 10; end
         endcase
         step_val = (p == 1 || p == 4) ? 20'd65535 : (p == 2) ? 20'd0 :
                    CSR_DATA_W'($urandom_range(65535));
         reg_val = (p == 1) ? 20'd0 : (p == 9) ? 20'hfffff :
                   CSR_DATA_W'($urandom_range(1) ? $urandom_range(4095) : $urandom);
         leak_val = (p == 5) ? 20'd0 : (p == 13) ? 20'h1ffff : (p == 3) ? 20'd65536 :
                    CSR_DATA_W'($urandom_range(131071));
         // Upper bits beyond the mode width must be dropped by the block.
         write_reg(CSR_UPDATE_MODE, {17'($urandom), 3'(p % 8)});
         write_reg(CSR_STEP_SIZE, step_val | {4'($urandom), 16'd0});
         write_reg(CSR_REGULARIZER, reg_val);
         write_reg(CSR_LEAK_FACTOR, leak_val | {3'($urandom), 17'd0});
         write_reg(CSR_UNMAPPED, 20'($urandom));
         end_writes();
         zero_run = (p == 1) ? 20 : 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            r.new_sample = pick_sample();
            r.desired = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 16'h7fff : 16'h8000)
                                                 : 16'($urandom);
            send_item(r, 1'b0, typed);
         end
      end
      req_valid <= 1'b0;
      drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Ran %0d items through all eight mode codes over %0d register settings;",
               items_sent, PHASES + 1);
      $display("%0d results checked, %0d mismatches.", rsps_seen, fail_count);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
